### hw/rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared helpers for writing clocked concurrent assertions.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `ASSERT_AT(lbl, clk, rst, !(expr), msg)

`endif

### hw/rtl/ccs_pkg.sv
// ============================================================================
// C comment stripper package
// Shared types, character codes and sizing constants.
// ============================================================================
package ccs_pkg;

   // Default width of the line counter.
   localparam int LINE_BITS_DEF = 32;

   // Number of entries in the queue between the scanner and the output side.
   localparam int QUEUE_DEPTH = 4;

   // Character codes the scanner reacts to.
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // Scanner states.
   typedef enum logic [2:0] {
      ST_CODE    = 3'd0,
      ST_QUOTE   = 3'd1,
      ST_SLASH   = 3'd2,
      ST_COMMENT = 3'd3,
      ST_STAR    = 3'd4
   } scan_state_type;

   // Input word.
   typedef struct packed {
      logic       command;
      logic [7:0] in_byte;
   } req_type;

   // Result word.
   typedef struct packed {
      logic        is_report;
      logic [7:0]  out_byte;
      logic        unterminated;
      logic [31:0] error_line;
      logic        last;
   } rsp_type;

   // Work for the output side: one or two results from one input word.
   // When report is set, the final result is the end-of-input status.
   typedef struct packed {
      logic        two;
      logic        report;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic        unterminated;
      logic [31:0] error_line;
   } act_type;

endpackage

### hw/rtl/c_comment_stripper_core.sv
// ============================================================================
// C comment stripper core
// Removes C block comments from a byte stream and reports open comments.
// ============================================================================
// One word is taken per cycle while the four-entry work queue has room; the
// scanner step finishes in that cycle. Results leave the output register at
// one word per cycle while rsp_ready is high, so a byte that yields one
// character takes one output word and a byte that yields two (a held slash
// plus the byte, or a held slash plus the end status) takes two, which sets
// the sustained rate. Results pass the queue, then the output register.
// Each comment becomes one space with its newlines kept; an end word gives
// a status word with the start line of any open comment.
`include "assert_macros.svh"

module c_comment_stripper_core #(
   parameter int LINE_BITS = ccs_pkg::LINE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ccs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ccs_pkg::rsp_type rsp_data
);
   import ccs_pkg::*;

   logic    push;
   act_type push_data;
   logic    q_full;
   logic    q_valid;
   logic    q_pop;
   act_type q_data;
   logic    rsp_report;
   logic    char_status;

   ccs_front #(
      .LINE_BITS (LINE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   ccs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_data    (q_data)
   );

   ccs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Status fields of the current result word, for the checks below.
   assign rsp_report  = rsp_valid && rsp_data.is_report;
   assign char_status = rsp_valid && !rsp_data.is_report &&
                        (rsp_data.unterminated || (rsp_data.error_line != 32'b0));

   // Queue never overflows or underflows.
   `ASSERT_AT(a_push_room, clock, reset, push |-> !q_full, "push into full queue")
   `ASSERT_AT(a_pop_entry, clock, reset, q_pop |-> q_valid, "pop from empty queue")
   // A status word always closes its item; a character word carries no status.
   `ASSERT_AT(a_report_last, clock, reset, rsp_report |-> rsp_data.last, "status word not last")
   `ASSERT_NEVER(a_char_clean, clock, reset, char_status, "character word carries status")

endmodule

### hw/rtl/ccs_front.sv
// ============================================================================
// Comment stripper scanner
// Runs the comment automaton on each accepted word and queues its results.
// ============================================================================
module ccs_front #(
   parameter int LINE_BITS = ccs_pkg::LINE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ccs_pkg::req_type req_data,
   input  logic             q_full,
   output logic             push,
   output ccs_pkg::act_type push_data
);
   import ccs_pkg::*;

   scan_state_type         state_ff, state_in;
   logic                   quote_ff, quote_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [LINE_BITS-1:0]   clines_ff, clines_in;
   logic                   accept;
   logic [7:0]             c;
   logic [1:0]             nres;
   logic                   bump;
   logic                   cbump;
   logic                   clr;
   logic                   is_quote;
   logic [LINE_BITS-1:0]   start_line;
   logic [LINE_BITS+31:0]  start_ext;
   logic [31:0]            start_sat;
   act_type                act;

   // A word is taken whenever the queue has room.
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign c         = req_data.in_byte;
   assign is_quote  = (c == CH_DQUOTE) || (c == CH_SQUOTE);

   // Start line of an open comment, clamped to the 32-bit result field.
   assign start_line = line_ff - clines_ff;
   assign start_ext  = {32'b0, start_line};
   assign start_sat  = (|start_ext[LINE_BITS+31:32]) ? 32'hFFFF_FFFF : start_ext[31:0];

   // Next state and results for the current word.
   always_comb begin
      state_in         = state_ff;
      quote_in         = quote_ff;
      line_in          = line_ff;
      clines_in        = clines_ff;
      nres             = 2'd0;
      bump             = 1'b0;
      cbump            = 1'b0;
      clr              = 1'b0;
      act.two          = 1'b0;
      act.report       = 1'b0;
      act.byte0        = c;
      act.byte1        = c;
      act.unterminated = 1'b0;
      act.error_line   = 32'b0;

      if (req_data.command) begin
         // End of input flushes a pending slash, reports, and starts over.
         act.report = 1'b1;
         if (state_ff == ST_SLASH) begin
            nres      = 2'd2;
            act.byte0 = CH_SLASH;
         end else begin
            nres = 2'd1;
         end
         if ((state_ff == ST_COMMENT) || (state_ff == ST_STAR)) begin
            act.unterminated = 1'b1;
            act.error_line   = start_sat;
         end
         state_in  = ST_CODE;
         quote_in  = 1'b0;
         line_in   = LINE_BITS'(1);
         clines_in = '0;
      end else begin
         unique case (state_ff)
            ST_QUOTE: begin
               nres = 2'd1;
               if ((c == CH_DQUOTE && quote_ff) || (c == CH_SQUOTE && !quote_ff)) begin
                  state_in = ST_CODE;
               end else if (c == CH_NL) begin
                  bump = 1'b1;
               end
            end
            ST_SLASH: begin
               if (c == CH_STAR) begin
                  nres      = 2'd1;
                  act.byte0 = CH_SPACE;
                  clr       = 1'b1;
                  state_in  = ST_COMMENT;
               end else if (c == CH_SLASH) begin
                  nres      = 2'd1;
                  act.byte0 = CH_SLASH;
               end else begin
                  // The held slash goes out, then the byte as in code.
                  nres      = 2'd2;
                  act.byte0 = CH_SLASH;
                  if (is_quote) begin
                     quote_in = (c == CH_DQUOTE);
                     state_in = ST_QUOTE;
                  end else begin
                     bump     = (c == CH_NL);
                     state_in = ST_CODE;
                  end
               end
            end
            ST_COMMENT: begin
               if (c == CH_NL) begin
                  nres  = 2'd1;
                  bump  = 1'b1;
                  cbump = 1'b1;
               end else if (c == CH_STAR) begin
                  state_in = ST_STAR;
               end
            end
            ST_STAR: begin
               if (c == CH_SLASH) begin
                  clr      = 1'b1;
                  state_in = ST_CODE;
               end else if (c == CH_NL) begin
                  nres     = 2'd1;
                  bump     = 1'b1;
                  cbump    = 1'b1;
                  state_in = ST_COMMENT;
               end else if (c != CH_STAR) begin
                  state_in = ST_COMMENT;
               end
            end
            default: begin
               // Code state; unused codes behave the same way.
               if (is_quote) begin
                  nres     = 2'd1;
                  quote_in = (c == CH_DQUOTE);
                  state_in = ST_QUOTE;
               end else if (c == CH_SLASH) begin
                  state_in = ST_SLASH;
               end else begin
                  nres     = 2'd1;
                  bump     = (c == CH_NL);
                  state_in = ST_CODE;
               end
            end
         endcase

         // Line counter saturates; comment lines follow only real increments.
         if (bump && (line_ff != '1)) begin
            line_in = line_ff + LINE_BITS'(1);
            if (cbump) begin
               clines_in = clines_ff + LINE_BITS'(1);
            end
         end
         if (clr) begin
            clines_in = '0;
         end
      end

      act.two = (nres == 2'd2);
   end

   assign push      = accept && (nres != 2'd0);
   assign push_data = act;

   // Scanner state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CODE;
         quote_ff  <= 1'b0;
         line_ff   <= LINE_BITS'(1);
         clines_ff <= '0;
      end else if (accept) begin
         state_ff  <= state_in;
         quote_ff  <= quote_in;
         line_ff   <= line_in;
         clines_ff <= clines_in;
      end
   end

endmodule

### hw/rtl/ccs_queue.sv
// ============================================================================
// Comment stripper work queue
// Small FIFO of pending result work between the scanner and output side.
// ============================================================================
module ccs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ccs_pkg::act_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             q_valid,
   output ccs_pkg::act_type q_data
);
   import ccs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   act_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_data  = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/ccs_back.sv
// ============================================================================
// Comment stripper output side
// Expands queued work into result words through an output register.
// ============================================================================
module ccs_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  ccs_pkg::act_type q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ccs_pkg::rsp_type rsp_data
);
   import ccs_pkg::*;

   logic    sub_ff, sub_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    load;
   logic    final_res;
   logic    is_rep;

   // A new word is loaded when the output register is empty or being taken.
   assign load      = q_valid && (!rsp_valid_ff || rsp_ready);
   assign final_res = sub_ff || !q_data.two;
   assign is_rep    = q_data.report && final_res;
   assign q_pop     = load && final_res;

   // Build the next result word from the head entry.
   always_comb begin
      rsp_data_in.is_report    = is_rep;
      rsp_data_in.out_byte     = is_rep ? 8'h00 : (sub_ff ? q_data.byte1 : q_data.byte0);
      rsp_data_in.unterminated = is_rep && q_data.unterminated;
      rsp_data_in.error_line   = is_rep ? q_data.error_line : 32'b0;
      rsp_data_in.last         = final_res;

      sub_in       = load ? !final_res : sub_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
